/* sv/lct_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// LRU cache table package
// Operation codes, field widths and the command passed to the recency logic.
// ----------------------------------------------------------------------------
package lct_pkg;

    localparam int OP_W    = 2;
    localparam int KEY_W   = 32;
    localparam int VALUE_W = 32;

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_ERASE  = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef struct packed {
        logic promote;
        logic insert;
        logic erase;
    } lct_cmd_t;

endpackage
`default_nettype wire

/* sv/lru_cache_table_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// LRU cache table
// Fully associative key-value store with least-recently-used replacement.
// A request is taken on any cycle; busy stays low. Its result strobe done is
// registered from the request-valid register, one result per request. The key
// compare over all entries and the rank update run while that register is set.
// Reset clears all valid marks at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module lru_cache_table_top #(
    parameter int CAPACITY = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [lct_pkg::OP_W-1:0]    op,
    input  wire logic [lct_pkg::KEY_W-1:0]   key,
    input  wire logic [lct_pkg::VALUE_W-1:0] value,
    output logic                             done,
    output logic                             found,
    output logic      [lct_pkg::VALUE_W-1:0] value_out,
    output logic                             evicted
);

    import lct_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic               req_valid_reg;
    op_t                op_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VALUE_W-1:0] value_reg;

    logic               done_reg;
    logic               found_reg;
    logic               evicted_reg;
    logic               lookup_hit_reg;
    logic               found_next;
    logic               evicted_next;
    logic               lookup_hit_next;

    logic [CAPACITY-1:0] hit;
    logic [CAPACITY-1:0] valid;
    logic [IW-1:0]       hit_idx;
    logic [IW-1:0]       wr_idx;
    logic                full;
    logic                hit_any;
    lct_cmd_t            cmd;
    logic [VALUE_W-1:0]  rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg  <= 1'b0;
            done_reg       <= 1'b0;
            found_reg      <= 1'b0;
            evicted_reg    <= 1'b0;
            lookup_hit_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg  <= start && !busy;
            done_reg       <= req_valid_reg;
            found_reg      <= found_next;
            evicted_reg    <= evicted_next;
            lookup_hit_reg <= lookup_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            op_reg    <= op_t'(op);
            key_reg   <= key;
            value_reg <= value;
        end
    end

    always_comb
    begin
        hit_any         = |hit;
        cmd             = '0;
        found_next      = 1'b0;
        lookup_hit_next = 1'b0;
        if (req_valid_reg)
        begin
            case (op_reg)
                OP_LOOKUP:
                begin
                    found_next      = hit_any;
                    lookup_hit_next = hit_any;
                    cmd.promote     = hit_any;
                end
                OP_INSERT:
                begin
                    found_next  = hit_any;
                    cmd.promote = hit_any;
                    cmd.insert  = !hit_any;
                end
                OP_ERASE:
                begin
                    found_next = hit_any;
                    cmd.erase  = hit_any;
                end
                default:
                begin
                    found_next = 1'b0;
                end
            endcase
        end
        evicted_next = cmd.insert && full;
    end

    lct_key_cam #(
        .CAPACITY (CAPACITY)
    ) u_key_cam (
        .clk     (clk),
        .key     (key_reg),
        .valid   (valid),
        .we      (cmd.insert),
        .wr_idx  (wr_idx),
        .hit     (hit),
        .hit_idx (hit_idx)
    );

    lct_recency #(
        .CAPACITY (CAPACITY)
    ) u_recency (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .hit    (hit),
        .valid  (valid),
        .full   (full),
        .wr_idx (wr_idx)
    );

    lct_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_value_ram (
        .clk   (clk),
        .we    (cmd.insert),
        .waddr (wr_idx),
        .wdata (value_reg),
        .re    (lookup_hit_next),
        .raddr (hit_idx),
        .rdata (rdata)
    );

    assign busy      = 1'b0;
    assign done      = done_reg;
    assign found     = found_reg;
    assign evicted   = evicted_reg;
    assign value_out = lookup_hit_reg ? rdata : '0;

endmodule
`default_nettype wire

/* sv/lct_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

/* sv/lct_key_cam.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// LRU cache table key store
// Holds the keys in registers and compares all valid entries in parallel.
// ----------------------------------------------------------------------------
module lct_key_cam #(
    parameter int CAPACITY = 16,
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  wire logic                      clk,
    input  wire logic [lct_pkg::KEY_W-1:0] key,
    input  wire logic [CAPACITY-1:0]       valid,
    input  wire logic                      we,
    input  wire logic [IW-1:0]             wr_idx,
    output logic      [CAPACITY-1:0]       hit,
    output logic      [IW-1:0]             hit_idx
);

    import lct_pkg::*;

    logic [KEY_W-1:0] key_reg [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            key_reg[wr_idx] <= key;
        end
    end

    always_comb
    begin
        hit     = '0;
        hit_idx = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            hit[i] = valid[i] && (key_reg[i] == key);
            if (hit[i])
            begin
                hit_idx = hit_idx | IW'(i);
            end
        end
    end

endmodule
`default_nettype wire

/* sv/lct_recency.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// LRU cache table recency tracker
// Keeps valid marks, recency ranks and the entry count, and picks the slot
// that a new key goes into.
// ----------------------------------------------------------------------------
module lct_recency #(
    parameter int CAPACITY = 16,
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lct_pkg::lct_cmd_t cmd,
    input  wire logic [CAPACITY-1:0] hit,
    output logic      [CAPACITY-1:0] valid,
    output logic                     full,
    output logic      [IW-1:0]       wr_idx
);

    import lct_pkg::*;

    logic [CAPACITY-1:0] valid_reg;
    logic [CAPACITY-1:0] valid_next;
    logic [IW-1:0]       rank_reg  [CAPACITY];
    logic [IW-1:0]       rank_next [CAPACITY];
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;

    logic [IW-1:0]       hit_rank;
    logic [CAPACITY-1:0] victim;
    logic [CAPACITY-1:0] free_sel;
    logic [CAPACITY-1:0] slot;
    logic                taken;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < CAPACITY; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            for (int i = 0; i < CAPACITY; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    always_comb
    begin
        hit_rank = '0;
        free_sel = '0;
        taken    = 1'b0;
        wr_idx   = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (hit[i])
            begin
                hit_rank = hit_rank | rank_reg[i];
            end
            victim[i] = valid_reg[i] && (rank_reg[i] == IW'(CAPACITY - 1));
            if (!valid_reg[i] && !taken)
            begin
                free_sel[i] = 1'b1;
                taken       = 1'b1;
            end
        end

        full = (count_reg == CW'(CAPACITY));
        slot = full ? victim : free_sel;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (slot[i])
            begin
                wr_idx = wr_idx | IW'(i);
            end
        end

        valid_next = valid_reg;
        count_next = count_reg;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rank_next[i] = rank_reg[i];
        end

        if (cmd.promote)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (hit[i])
                begin
                    rank_next[i] = '0;
                end
                else if (valid_reg[i] && (rank_reg[i] < hit_rank))
                begin
                    rank_next[i] = rank_reg[i] + 1'b1;
                end
            end
        end
        else if (cmd.insert)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (slot[i])
                begin
                    valid_next[i] = 1'b1;
                    rank_next[i]  = '0;
                end
                else if (valid_reg[i])
                begin
                    rank_next[i] = rank_reg[i] + 1'b1;
                end
            end
            if (!full)
            begin
                count_next = count_reg + 1'b1;
            end
        end
        else if (cmd.erase)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (hit[i])
                begin
                    valid_next[i] = 1'b0;
                    rank_next[i]  = '0;
                end
                else if (valid_reg[i] && (rank_reg[i] > hit_rank))
                begin
                    rank_next[i] = rank_reg[i] - 1'b1;
                end
            end
            count_next = count_reg - 1'b1;
        end
    end

    assign valid = valid_reg;

endmodule
`default_nettype wire

/* verif/lru_cache_table_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU cache table checker
// Watches the request and result channels of the cache table, keeps its own
// model of the keys, values and recency ranks, and compares every result
// strobe with the oldest predicted result.
// ----------------------------------------------------------------------------
module lru_cache_table_checker #(
    parameter int CAPACITY = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic                        busy,
    input  wire logic [lct_pkg::OP_W-1:0]    op,
    input  wire logic [lct_pkg::KEY_W-1:0]   key,
    input  wire logic [lct_pkg::VALUE_W-1:0] value,
    input  wire logic                        done,
    input  wire logic                        found,
    input  wire logic [lct_pkg::VALUE_W-1:0] value_out,
    input  wire logic                        evicted,
    output int                               fail_count,
    output int                               outstanding
);

    import lct_pkg::*;

    typedef struct packed {
        logic               found;
        logic [VALUE_W-1:0] value_out;
        logic               evicted;
    } lookup_result_t;

    logic [KEY_W-1:0]   slot_key   [CAPACITY];
    logic [VALUE_W-1:0] slot_value [CAPACITY];
    bit                 slot_valid [CAPACITY];
    int                 slot_rank  [CAPACITY];
    int                 slot_count;
    lookup_result_t     pending_results [$];
    int                 errors;

    task automatic promote_slot(input int idx);
        int r;
        r = slot_rank[idx];
        for (int i = 0; i < CAPACITY; i++)
            if (slot_valid[i] && slot_rank[i] < r)
                slot_rank[i]++;
        slot_rank[idx] = 0;
    endtask

    task automatic drop_slot(input int idx);
        int r;
        r = slot_rank[idx];
        for (int i = 0; i < CAPACITY; i++)
            if (slot_valid[i] && slot_rank[i] > r)
                slot_rank[i]--;
        slot_valid[idx] = 1'b0;
        slot_rank[idx]  = 0;
        if (slot_count > 0)
            slot_count--;
    endtask

    task automatic lru_predict(input op_t cmd, input logic [KEY_W-1:0] k,
                               input logic [VALUE_W-1:0] v, output lookup_result_t res);
        int hit;
        int oldest;
        int free_slot;
        res = '0;
        hit = -1;
        for (int i = 0; i < CAPACITY; i++)
            if (hit < 0 && slot_valid[i] && slot_key[i] == k)
                hit = i;
        if (cmd != OP_NOP)
            res.found = (hit >= 0);
        case (cmd)
            OP_LOOKUP:
            begin
                if (hit >= 0)
                begin
                    res.value_out = slot_value[hit];
                    promote_slot(hit);
                end
            end
            OP_INSERT:
            begin
                if (hit >= 0)
                begin
                    promote_slot(hit);
                end
                else
                begin
                    if (slot_count >= CAPACITY)
                    begin
                        oldest = -1;
                        for (int i = 0; i < CAPACITY; i++)
                            if (slot_valid[i] &&
                                (oldest < 0 || slot_rank[i] > slot_rank[oldest]))
                                oldest = i;
                        if (oldest >= 0)
                        begin
                            drop_slot(oldest);
                            res.evicted = 1'b1;
                        end
                    end
                    free_slot = -1;
                    for (int i = 0; i < CAPACITY; i++)
                        if (free_slot < 0 && !slot_valid[i])
                            free_slot = i;
                    if (free_slot >= 0)
                    begin
                        for (int i = 0; i < CAPACITY; i++)
                            if (slot_valid[i])
                                slot_rank[i]++;
                        slot_valid[free_slot] = 1'b1;
                        slot_key[free_slot]   = k;
                        slot_value[free_slot] = v;
                        slot_rank[free_slot]  = 0;
                        slot_count++;
                    end
                end
            end
            OP_ERASE:
            begin
                if (hit >= 0)
                    drop_slot(hit);
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk)
    begin : monitor
        lookup_result_t got;
        lookup_result_t want;
        lookup_result_t predicted;
        if (!rst_n)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                slot_valid[i] = 1'b0;
                slot_rank[i]  = 0;
            end
            slot_count = 0;
            pending_results.delete();
        end
        else
        begin
            if (done)
            begin
                got.found     = found;
                got.value_out = value_out;
                got.evicted   = evicted;
                if (pending_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected result: found=%0b value_out=%h evicted=%0b",
                                 $realtime, got.found, got.value_out, got.evicted);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.found !== want.found || got.value_out !== want.value_out ||
                        got.evicted !== want.evicted)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: mismatch, expected/actual:", $realtime,
                                     " found %0b/%0b value_out %h/%h evicted %0b/%0b",
                                     want.found, got.found, want.value_out,
                                     got.value_out, want.evicted, got.evicted);
                    end
                end
            end
            if (start && !busy)
            begin
                lru_predict(op_t'(op), key, value, predicted);
                pending_results.push_back(predicted);
            end
        end
        fail_count  <= errors;
        outstanding <= pending_results.size();
    end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU cache table testbench
// Drives directed and random lookup, insert, erase and no-op requests with random
// gaps into the cache table and takes the verdict from the checker.
// ----------------------------------------------------------------------------
module testbench;

    import lct_pkg::*;

    localparam int CAPACITY  = 16;
    localparam int POOL_SIZE = 24;
    localparam int LIMIT     = 200000;

    logic               clk   = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [OP_W-1:0]    op    = OP_NOP;
    logic [KEY_W-1:0]   key   = '0;
    logic [VALUE_W-1:0] value = '0;
    logic               busy;
    logic               done;
    logic               found;
    logic [VALUE_W-1:0] value_out;
    logic               evicted;
    int                 fail_count;
    int                 outstanding;
    int                 cycles = 0;

    logic [KEY_W-1:0]   key_pool [POOL_SIZE];
    int                 pool_span = POOL_SIZE;
    bit                 no_idle = 1'b0;

    always #5 clk = ~clk;

    lru_cache_table_top #(
        .CAPACITY (CAPACITY)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .op        (op),
        .key       (key),
        .value     (value),
        .done      (done),
        .found     (found),
        .value_out (value_out),
        .evicted   (evicted)
    );

    lru_cache_table_checker #(
        .CAPACITY (CAPACITY)
    ) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .key         (key),
        .value       (value),
        .done        (done),
        .found       (found),
        .value_out   (value_out),
        .evicted     (evicted),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    task automatic issue(input op_t cmd, input logic [KEY_W-1:0] k, input logic [VALUE_W-1:0] v);
        int gap;
        int r;
        @(negedge clk);
        start <= 1'b1;
        op    <= cmd;
        key   <= k;
        value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        r = $urandom_range(0, 99);
        if (no_idle)
            gap = 0;
        else if (r < 80)
            gap = $urandom_range(0, 2);
        else if (r < 95)
            gap = $urandom_range(3, 8);
        else
            gap = $urandom_range(20, 40);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    initial
    begin
        op_t              cmd;
        logic [KEY_W-1:0] k;
        int               r;
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = $urandom();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: misses on an empty table, extreme keys and values, the
        // unused operation code, a repeated insert, and an eviction from a full table.
        issue(OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
        issue(OP_ERASE,  32'h0000_0000, 32'h0000_0000);
        issue(OP_NOP,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue(OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
        issue(OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
        issue(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        issue(OP_INSERT, 32'h0000_0000, 32'h1234_5678);
        issue(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        issue(OP_ERASE,  32'hFFFF_FFFF, 32'h0000_0000);
        issue(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
        for (int n = 1; n <= CAPACITY; n++)
            issue(OP_INSERT, n, ~n);
        issue(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);

        for (int n = 0; n < 600; n++)
        begin
            if (n % 100 == 0)
            begin
                pool_span = $urandom_range(4, POOL_SIZE);
                no_idle   = ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 99);
            if (r < 40)
                cmd = OP_LOOKUP;
            else if (r < 75)
                cmd = OP_INSERT;
            else if (r < 95)
                cmd = OP_ERASE;
            else
                cmd = OP_NOP;
            if ($urandom_range(0, 99) < 85)
                k = key_pool[$urandom_range(0, pool_span - 1)];
            else
                k = $urandom();
            issue(cmd, k, $urandom());
        end

        @(negedge clk);
        start <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
